FILE: rtl/core/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

    // crc-16 parameters (reflected form)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // frame byte positions
    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_COUNT    = 9'd2;
    localparam logic [POS_W-1:0] POS_SPEED_HI = 9'd3;
    localparam logic [POS_W-1:0] POS_SPEED_LO = 9'd4;
    localparam logic [POS_W-1:0] POS_DIR_HI   = 9'd5;
    localparam logic [POS_W-1:0] POS_DIR_LO   = 9'd6;
    localparam logic [POS_W-1:0] CRC_OFFSET   = 9'd3;

    // data byte count below this marks a short frame
    localparam logic [7:0] MIN_COUNT = 8'd4;

    // stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 72;

    // one checked frame
    typedef struct packed {
        logic        short_frame;
        logic [15:0] wind_direction;
        logic [15:0] wind_speed;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
        logic        crc_ok;
    } t_result;

    // one byte of the reflected crc, bit-parallel
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/modbus_response_checker.sv
// Modbus RTU read-holding-registers response checker.
// Slave side takes one received byte per item: tdata carries the byte,
// tuser is high on the first (slave address) byte of a frame. A start byte
// during an open frame drops that frame; bytes outside a frame are dropped.
// Byte 2 gives the data count N; crc-16 (reflected, 0xA001, init 0xFFFF)
// runs over bytes 0..N+2 and is checked against bytes N+3 (low), N+4 (high).
// Master side gives one item per complete frame: crc status, received and
// computed crc, two big-endian registers (zero when N < 4), short flag.
// Throughput: one byte per cycle while the master side takes results, set by
// the combinational crc byte update on the frame state register. The last
// crc byte lands in the input register when accepted, and the result register
// loads once that byte moves on; the result is then valid on the master side.
// When the master side stalls, the result is held and one more byte is
// buffered in the input register before s tready drops.
// Reset (synchronous, active low) empties both registers and closes any
// open frame.
`default_nettype none

module modbus_response_checker
    import mrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                  i_s_axis_tuser,  // [0] frame_start
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] crc_ok, [16:1] crc_received, [32:17] crc_computed,
    // [48:33] wind_speed, [64:49] wind_direction, [65] short_frame, rest 0
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_start;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 w_adv;
    logic                 w_res_valid;
    t_result              w_result;

    // the held byte moves on when the result register is free
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
    end

    mrc_frame_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_rx_byte     (r_in_byte),
        .i_frame_start (r_in_start),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

`default_nettype wire

FILE: rtl/core/mrc_frame_tracker.sv
`default_nettype none

module mrc_frame_tracker
    import mrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_frame_start,
    output logic            o_res_valid,
    output t_result         o_result
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_low, n_low;
    logic [15:0]      r_speed, n_speed;
    logic [15:0]      r_dir, n_dir;
    logic             r_active, n_active;

    logic [POS_W-1:0] w_pos;
    logic [7:0]       w_count;
    logic [15:0]      w_crc;
    logic [7:0]       w_low;
    logic [15:0]      w_speed;
    logic [15:0]      w_dir;
    logic             w_active;
    logic [POS_W-1:0] w_limit;
    logic [15:0]      w_rx_crc;

    // a start byte opens a fresh frame
    always_comb begin
        w_active = i_frame_start | r_active;
        w_pos    = i_frame_start ? '0 : r_pos;
        w_count  = i_frame_start ? '0 : r_count;
        w_crc    = i_frame_start ? CRC_INIT : r_crc;
        w_low    = i_frame_start ? '0 : r_low;
        w_speed  = i_frame_start ? '0 : r_speed;
        w_dir    = i_frame_start ? '0 : r_dir;
    end

    // next state and result for the current byte
    always_comb begin
        n_pos       = r_pos;
        n_count     = r_count;
        n_crc       = r_crc;
        n_low       = r_low;
        n_speed     = r_speed;
        n_dir       = r_dir;
        n_active    = r_active;
        o_res_valid = 1'b0;
        w_limit     = '0;
        w_rx_crc    = {i_rx_byte, w_low};

        if (i_en && w_active) begin
            n_active = 1'b1;
            n_pos    = w_pos + 1'b1;
            n_count  = (w_pos == POS_COUNT) ? i_rx_byte : w_count;
            n_crc    = w_crc;
            n_low    = w_low;
            n_speed  = w_speed;
            n_dir    = w_dir;

            // register bytes, big-endian
            case (w_pos)
                POS_SPEED_HI: n_speed = {i_rx_byte, w_speed[7:0]};
                POS_SPEED_LO: n_speed = {w_speed[15:8], i_rx_byte};
                POS_DIR_HI:   n_dir   = {i_rx_byte, w_dir[7:0]};
                POS_DIR_LO:   n_dir   = {w_dir[15:8], i_rx_byte};
                default: ;
            endcase

            w_limit = {1'b0, n_count} + CRC_OFFSET;

            // header and data feed the crc, then two crc bytes
            if (w_pos < w_limit || w_pos <= POS_COUNT) begin
                n_crc = crc_byte(w_crc, i_rx_byte);
            end else if (w_pos == w_limit) begin
                n_low = i_rx_byte;
            end else begin
                o_res_valid = 1'b1;
                n_active    = 1'b0;
            end
        end
    end

    // result fields, taken when o_res_valid is high
    always_comb begin
        o_result.crc_received   = w_rx_crc;
        o_result.crc_computed   = w_crc;
        o_result.crc_ok         = (w_rx_crc == w_crc);
        o_result.short_frame    = (n_count < MIN_COUNT);
        o_result.wind_speed     = o_result.short_frame ? '0 : n_speed;
        o_result.wind_direction = o_result.short_frame ? '0 : n_dir;
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_low    <= '0;
            r_speed  <= '0;
            r_dir    <= '0;
            r_active <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_low    <= n_low;
            r_speed  <= n_speed;
            r_dir    <= n_dir;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire
